FILE: design/fppd_pkg.sv
`timescale 1ns / 1ps

package fppd_pkg;

	localparam int POOL_SLOTS = 8;
	localparam int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int FILL_W     = $clog2(POOL_SLOTS + 1);
	localparam int SUM_W      = FILL_W + 1;

	localparam int MID_W      = 16;
	localparam int ROW_W      = 12;
	localparam int COL_W      = 12;
	localparam int OSLOT_W    = 3;

	// page tag, matrix id in the high bits
	typedef struct packed {
		logic [MID_W-1:0] matrix_id;
		logic [ROW_W-1:0] block_row;
		logic [COL_W-1:0] block_col;
	} tag_t;

	// one directory entry as it moves down the row
	typedef struct packed {
		logic              valid;
		tag_t              tag;
		logic [SLOT_W-1:0] slot;
	} entry_t;

	// lookup result rippling through the row
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
	} match_t;

	// per-cycle control common to every cell
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	// (a + b) mod POOL_SLOTS for a < POOL_SLOTS, b < POOL_SLOTS
	function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
			input logic [FILL_W-1:0] b);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(a) + SUM_W'(b);
		if (sum >= SUM_W'(POOL_SLOTS)) begin
			sum = sum - SUM_W'(POOL_SLOTS);
		end
		return sum[SLOT_W-1:0];
	endfunction

	// low three bits of a slot number
	function automatic logic [OSLOT_W-1:0] out_slot(input logic [SLOT_W-1:0] s);
		logic [SLOT_W+OSLOT_W-1:0] wide;
		wide = {{OSLOT_W{1'b0}}, s};
		return wide[OSLOT_W-1:0];
	endfunction

endpackage

FILE: design/fppd_cell.sv
`timescale 1ns / 1ps

module fppd_cell import fppd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    prev_entry,
	output entry_t    entry,
	input  tag_t      lookup_tag,
	input  match_t    match_in,
	output match_t    match_out
);

	logic              valid_q;
	tag_t              tag_q;
	logic [SLOT_W-1:0] slot_q;
	logic              match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= prev_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift && !ctl.clear) begin
			tag_q  <= prev_entry.tag;
			slot_q <= prev_entry.slot;
		end
	end

	assign entry = '{valid: valid_q, tag: tag_q, slot: slot_q};

	// pages are never duplicated, so at most one cell matches
	assign match          = valid_q && (tag_q == lookup_tag);
	assign match_out.hit  = match_in.hit | match;
	assign match_out.slot = match_in.slot | (match ? slot_q : '0);

endmodule

FILE: design/fifo_page_pool_directory.sv
`timescale 1ns / 1ps
// fifo page pool directory: fully associative, first-in-first-out replacement
// the result is registered and appears on m_tvalid in the cycle after the request is taken
// throughput: one request per cycle while m_tready keeps up; the tag compare ripples
// through the cell row and the row shifts once per miss, all within the accepting cycle
// reset: arst_n clears all valid bits, oldest slot, fill count and the result valid flag

module fifo_page_pool_directory import fppd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // matrix_id[15:0], block_row[27:16], block_col[39:28]
	input  logic [0:0]  s_tuser,   // mode[0]
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // slot[2:0], evicted_matrix_id[18:3],
	                               // evicted_block_row[30:19], evicted_block_col[42:31],
	                               // zero[47:43]
	output logic [1:0]  m_tuser    // hit[0], evicted[1]
);

	// request fields
	logic  mode;
	tag_t  req_tag;

	assign mode              = s_tuser[0];
	assign req_tag.matrix_id = s_tdata[15:0];
	assign req_tag.block_row = s_tdata[27:16];
	assign req_tag.block_col = s_tdata[39:28];

	// fifo bookkeeping
	logic [SLOT_W-1:0] oldest_q;
	logic [FILL_W-1:0] fill_q;
	logic              full;

	assign full = (fill_q == FILL_W'(POOL_SLOTS));

	// output register
	logic              out_valid_q;
	logic              hit_q;
	logic              evicted_q;
	logic [OSLOT_W-1:0] slot_q;
	tag_t              ev_tag_q;

	logic accept;
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// cell row: entries[0] is the page being inserted, the youngest page sits
	// in cell 0 and the oldest at the far end once the pool is full
	entry_t    entries [POOL_SLOTS+1];
	match_t    match_chain [POOL_SLOTS+1];
	cell_ctl_t ctl;

	logic              lookup_hit;
	logic [SLOT_W-1:0] lookup_slot;
	logic [SLOT_W-1:0] new_slot;
	entry_t            oldest_entry;

	// free slot sits just after the youngest page; when full reuse the oldest
	assign new_slot = full ? oldest_q : slot_add(oldest_q, fill_q);

	assign entries[0]     = '{valid: 1'b1, tag: req_tag, slot: new_slot};
	assign match_chain[0] = '{hit: 1'b0, slot: '0};

	genvar gi;
	generate
		for (gi = 0; gi < POOL_SLOTS; gi++) begin : g_cell
			fppd_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.prev_entry (entries[gi]),
				.entry      (entries[gi+1]),
				.lookup_tag (req_tag),
				.match_in   (match_chain[gi]),
				.match_out  (match_chain[gi+1])
			);
		end
	endgenerate

	assign lookup_hit   = match_chain[POOL_SLOTS].hit;
	assign lookup_slot  = match_chain[POOL_SLOTS].slot;
	assign oldest_entry = entries[POOL_SLOTS];

	// clear wipes the row, a miss pushes the new page in at cell 0
	assign ctl.clear = accept && mode;
	assign ctl.shift = accept && !mode && !lookup_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			fill_q   <= '0;
		end else if (ctl.clear) begin
			oldest_q <= '0;
			fill_q   <= '0;
		end else if (ctl.shift) begin
			if (full) begin
				oldest_q <= (oldest_q == SLOT_W'(POOL_SLOTS - 1)) ? '0 : oldest_q + 1'b1;
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			if (mode) begin
				hit_q     <= 1'b0;
				slot_q    <= '0;
				evicted_q <= 1'b0;
				ev_tag_q  <= '0;
			end else if (lookup_hit) begin
				hit_q     <= 1'b1;
				slot_q    <= out_slot(lookup_slot);
				evicted_q <= 1'b0;
				ev_tag_q  <= '0;
			end else begin
				hit_q     <= 1'b0;
				slot_q    <= out_slot(new_slot);
				evicted_q <= full;
				// the page falling off the end of the row is the oldest one
				ev_tag_q  <= full ? oldest_entry.tag : '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {evicted_q, hit_q};
	assign m_tdata  = {5'b0, ev_tag_q.block_col, ev_tag_q.block_row, ev_tag_q.matrix_id,
	                   slot_q};

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import fppd_pkg::*;

	typedef enum logic {
		MODE_REQUEST = 1'b0,
		MODE_CLEAR   = 1'b1
	} mode_e;

	// one expected lookup outcome, laid out the way the checker compares it
	typedef struct packed {
		logic       hit;
		logic [2:0] slot;
		logic       evicted;
		tag_t       ev_tag;
	} page_result_t;

	localparam int STALL_LIMIT = 5000;   // cycles with no request or result moving
	localparam int IDLE_PCT    = 23;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;    // matrix_id[15:0], block_row[27:16], block_col[39:28]
	logic [0:0]  s_tuser  = '0;    // mode[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;          // slot[2:0], evicted_matrix_id[18:3],
	                               // evicted_block_row[30:19], evicted_block_col[42:31]
	logic [1:0]  m_tuser;          // hit[0], evicted[1]

	// shadow copy of the directory
	tag_t pool_tag   [POOL_SLOTS];
	logic pool_valid [POOL_SLOTS];
	int   oldest_page;
	int   page_count;

	page_result_t pending_results[$];

	int  errors         = 0;
	int  request_count  = 0;
	int  hit_count      = 0;
	int  eviction_count = 0;
	int  clear_count    = 0;
	bit  no_idle        = 1'b0;    // set during the back-to-back stretch

	tag_t page [8];                // pages used by the directed tests

	fifo_page_pool_directory i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// directory update for one accepted request; returns what the block should report
	function automatic page_result_t lookup_page(input mode_e mode, input tag_t tag);
		page_result_t r;
		int           s;
		bit           found;
		r     = '0;
		found = 1'b0;
		if (mode == MODE_CLEAR) begin
			for (int i = 0; i < POOL_SLOTS; i++) begin
				pool_valid[i] = 1'b0;
			end
			oldest_page = 0;
			page_count  = 0;
			clear_count++;
			return r;
		end
		request_count++;
		// first matching slot wins, only valid entries are compared
		for (int i = 0; i < POOL_SLOTS; i++) begin
			if (!found && pool_valid[i] && pool_tag[i] == tag) begin
				found  = 1'b1;
				r.hit  = 1'b1;
				r.slot = 3'(i);
			end
		end
		if (found) begin
			hit_count++;
			return r;
		end
		if (page_count < POOL_SLOTS) begin
			// free slot right after the youngest page
			s = (oldest_page + page_count) % POOL_SLOTS;
			page_count++;
		end else begin
			// pool full: the oldest page gives up its slot
			s           = oldest_page;
			r.evicted   = 1'b1;
			r.ev_tag    = pool_tag[s];
			oldest_page = (s + 1) % POOL_SLOTS;
			eviction_count++;
		end
		pool_tag[s]   = tag;
		pool_valid[s] = 1'b1;
		r.slot        = 3'(s);
		return r;
	endfunction

	// present one request, hold it until taken, then record its expected result
	task automatic send_request(input mode_e mode, input tag_t tag);
		if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {tag.block_col, tag.block_row, tag.matrix_id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.insert(pending_results.size(), lookup_page(mode, tag));
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	// result side: compare against the oldest expectation, then pick next ready
	always @(posedge clk) begin : result_check
		page_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, got tdata %h tuser %h",
					$time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				check_field("hit", 16'(want.hit), 16'(m_tuser[0]));
				check_field("evicted", 16'(want.evicted), 16'(m_tuser[1]));
				check_field("slot", 16'(want.slot), 16'(m_tdata[2:0]));
				check_field("evicted_matrix_id", want.ev_tag.matrix_id, m_tdata[18:3]);
				check_field("evicted_block_row", 16'(want.ev_tag.block_row),
					16'(m_tdata[30:19]));
				check_field("evicted_block_col", 16'(want.ev_tag.block_col),
					16'(m_tdata[42:31]));
				check_field("tdata padding", 16'h0, 16'(m_tdata[47:43]));
			end
		end
		m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
	end

	// watchdog: a stall that reaches STALL_LIMIT, with no handshake at all, ends the run
	initial begin : watchdog
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall = 0;
			end else begin
				stall++;
			end
		end
		$display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
		$display("FAIL");
		$finish;
	end

	// fill an empty pool, extreme tags first, slots should come out 0..7
	task automatic test_fill_and_extremes();
		page[0] = '0;
		page[1] = '1;
		for (int i = 2; i < 8; i++) begin
			page[i] = {16'(16'h1 << (2 * i)), 12'(i * 37), 12'(12'h800 >> i)};
		end
		for (int i = 0; i < 8; i++) begin
			send_request(MODE_REQUEST, page[i]);
		end
	endtask

	// hits on a full pool must not disturb the replacement order
	task automatic test_hits();
		send_request(MODE_REQUEST, page[7]);
		send_request(MODE_REQUEST, page[0]);
		send_request(MODE_REQUEST, page[1]);
	endtask

	// tags differing in one field only are misses and evict the oldest pages in turn
	task automatic test_fifo_eviction();
		tag_t t;
		t = page[0];
		t.block_col = 12'h001;
		send_request(MODE_REQUEST, t);
		t = page[0];
		t.block_row = 12'h001;
		send_request(MODE_REQUEST, t);
		t = page[0];
		t.matrix_id = 16'h0001;
		send_request(MODE_REQUEST, t);
		// the all-zero page was evicted first, so it comes back as a miss
		send_request(MODE_REQUEST, page[0]);
		send_request(MODE_REQUEST, page[0]);
	endtask

	// clear with all-ones, zero and other fields, on a full pool, a partly filled one and an empty one
	task automatic test_clear();
		send_request(MODE_CLEAR, '1);
		send_request(MODE_REQUEST, page[4]);
		send_request(MODE_CLEAR, '0);
		send_request(MODE_CLEAR, page[5]);
		send_request(MODE_REQUEST, page[1]);
	endtask

	// mostly a small working set so hits and evictions mix, plus random tags and clears
	task automatic test_random_traffic();
		tag_t    work_set [12];
		logic [15:0] mids [3];
		logic [11:0] rows [2];
		tag_t    t;
		int      pick;
		for (int k = 0; k < 1100; k++) begin
			if (k % 150 == 0) begin
				foreach (mids[j]) mids[j] = 16'($urandom);
				foreach (rows[j]) rows[j] = 12'($urandom);
				foreach (work_set[j]) begin
					work_set[j].matrix_id = mids[$urandom_range(2)];
					work_set[j].block_row = rows[$urandom_range(1)];
					work_set[j].block_col = 12'($urandom_range(7));
				end
			end
			no_idle = (k >= 300 && k < 500);
			if (k == 700) begin
				drain_results();
			end
			pick = $urandom_range(99);
			if (pick < 3) begin
				send_request(MODE_CLEAR, 40'({$urandom, $urandom}));
			end else if (pick < 28) begin
				send_request(MODE_REQUEST, 40'({$urandom, $urandom}));
			end else begin
				t = work_set[$urandom_range(11)];
				send_request(MODE_REQUEST, t);
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < POOL_SLOTS; i++) begin
			pool_tag[i]   = '0;
			pool_valid[i] = 1'b0;
		end
		oldest_page = 0;
		page_count  = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_and_extremes();
		test_hits();
		test_fifo_eviction();
		test_clear();
		test_random_traffic();

		drain_results();
		repeat (4) @(posedge clk);

		$display("covered %0d page requests and %0d pool clears under stalls on both sides",
			request_count, clear_count);
		$display("of the requests %0d hit and %0d forced out the oldest page",
			hit_count, eviction_count);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
